### hw/rtl/tone_sequence_interpreter_defines.svh
// Assertion macros for the tone sequence interpreter checker.
// No dependencies.
`ifndef TONE_SEQUENCE_INTERPRETER_DEFINES_SVH
`define TONE_SEQUENCE_INTERPRETER_DEFINES_SVH
// Implication checked on every rising clock edge, held off during reset.
`define TSI_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication checked on every rising clock edge, held off during reset.
`define TSI_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### hw/rtl/tsi_pkg.sv
// Shared types and constants for the tone sequence interpreter.
// No dependencies.
package tsi_pkg;
   localparam int SEQ_DEPTH_DEF   = 4096;
   localparam int BLOCK_COUNT_DEF = 128;
   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_EXEC    = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [1:0] CSR_BASE_VOL = 2'd0;
   localparam logic [1:0] CSR_MUTE     = 2'd1;
   localparam logic [1:0] CSR_SEQ_LEN  = 2'd2;

   localparam logic [2:0] KIND_TONE  = 3'd0;
   localparam logic [2:0] KIND_DUAL  = 3'd1;
   localparam logic [2:0] KIND_SIL   = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_ERR   = 3'd4;

   localparam logic signed [7:0] CODE_SIL   = -8'sd1;
   localparam logic signed [7:0] CODE_VER   = -8'sd2;
   localparam logic signed [7:0] CODE_TEMPO = -8'sd3;
   localparam logic signed [7:0] CODE_RES   = -8'sd4;
   localparam logic signed [7:0] CODE_BSTART= -8'sd5;
   localparam logic signed [7:0] CODE_BEND  = -8'sd6;
   localparam logic signed [7:0] CODE_PLAY  = -8'sd7;
   localparam logic signed [7:0] CODE_VOL   = -8'sd8;
   localparam logic signed [7:0] CODE_REP   = -8'sd9;
   localparam logic signed [7:0] CODE_DUAL  = -8'sd50;

   localparam logic [31:0] TICKS = 32'd240000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_DECODE,
      ST_BTAB, ST_DIV, ST_MUL, ST_EMIT
   } state_type;

   // Divider control between sequencer and divider.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [17:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage

### hw/rtl/tsi_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tsi_pkg.
module tsi_divider import tsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [31:0] quo_ff, quo_in;
   logic [18:0] rem_ff, rem_in;
   logic [17:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [18:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[17:0], quo_ff[31]};
      if (req.start) begin
         quo_in = req.dividend; rem_in = '0; dsr_in = req.divisor;
         cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

### hw/rtl/tone_sequence_interpreter.sv
// Top level of the tone sequence interpreter: sequencer, memories and stores.
// Depends on tsi_pkg and tsi_divider.
//
// A load or restart beat passes through ST_RD0 and returns to idle. An execute
// beat reads up to four sequence bytes through the single memory read port (one
// per cycle), then for a sounding event runs the serial divider, then the ST_MUL
// state for the repeat multiply and ST_EMIT to present the result. req_tready is
// high only when idle and no result is pending. The result register holds one
// beat; a new request is taken only once it is drained. No clearing pass: the
// block table has one valid bit per entry.
module tone_sequence_interpreter import tsi_pkg::*; #(
   parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF,
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] op, [13:2] load_address, [21:14] load_byte, zero fill
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] event_kind, [10:3] note_a, [18:11] note_b, [41:19] duration_ms,
   // [48:42] repeat_count, [55:49] volume, [87:56] elapsed_ms
   output logic [87:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   localparam int AW = $clog2(SEQ_DEPTH);
   localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam logic [16:0] DEPTH17 = 17'(SEQ_DEPTH);

   state_type state_ff, state_in;

   // configuration
   logic [6:0]  base_vol_ff;
   logic        mute_ff;
   logic [12:0] seq_len_ff;

   // interpreter state
   logic [16:0] off_ff, off_in;
   logic signed [9:0] tempo_ff, tempo_in;
   logic signed [7:0] res_ff, res_in;
   logic [6:0]  vol_ff, vol_in;
   logic [31:0] elap_ff, elap_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic        def_ff, def_in;

   // memories
   logic [7:0]  seq_mem [SEQ_DEPTH];
   logic [16:0] btab_mem [BLOCK_COUNT];
   logic [BLOCK_COUNT-1:0] bvalid_ff;
   logic [16:0] stack_mem [STACK_DEPTH];
   logic [7:0]  rd_data_ff;
   logic [16:0] btab_rd_ff, stack_rd_ff;

   // item registers
   logic [23:0] item_ff;
   logic signed [7:0] code_ff, parm_ff, n2_ff, n3_ff;
   logic [16:0] len17;
   logic [16:0] rd_addr;
   logic        div_neg_ff, div_neg_in;
   logic [31:0] dur_ff, dur_in;
   logic [87:0] out_ff, out_in;
   logic        out_v_ff, out_v_in;
   logic [3:0]  wstage_ff;
   div_req_type dreq;
   div_rsp_type drsp;

   logic [1:0]  req_op;
   logic [11:0] req_addr;
   logic [7:0]  req_byte;
   assign req_op = item_ff[1:0];
   assign req_addr = item_ff[13:2];
   assign req_byte = item_ff[21:14];

   assign len17 = ({4'd0, seq_len_ff} < DEPTH17) ? {4'd0, seq_len_ff} : DEPTH17;
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;

   tsi_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // sequencing helpers
   logic [16:0] need;
   logic        is_sound, has_room2, has_room_need;
   logic signed [7:0] dparm;
   logic signed [31:0] numer;
   logic signed [17:0] divsr;
   logic [6:0]  cnt7;
   logic [6:0]  note_clamp;
   logic [38:0] rep_prod;
   logic [32:0] sum;

   always_comb begin
      need = (code_ff == CODE_REP || code_ff == CODE_DUAL) ? 17'd4 : 17'd2;
      has_room2 = (off_ff < len17) && (len17 - off_ff >= 17'd2);
      has_room_need = (len17 - off_ff >= need);
      is_sound = !(code_ff == CODE_VER || code_ff == CODE_TEMPO ||
                   code_ff == CODE_RES || code_ff == CODE_BSTART ||
                   code_ff == CODE_BEND || code_ff == CODE_PLAY ||
                   code_ff == CODE_VOL);
      dparm = (code_ff == CODE_REP) ? n3_ff : parm_ff;
      numer = 32'(dparm) * 32'sd240000;
      divsr = 18'(res_ff) * 18'(tempo_ff);
      cnt7 = parm_ff[7] ? 7'd0 : parm_ff[6:0];
      note_clamp = code_ff[7] ? 7'd0 : code_ff[6:0];
      rd_addr = off_ff + 17'(wstage_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid && req_tready) state_in = ST_RD0;
         ST_RD0: begin
            if (req_op == OP_EXEC) state_in = has_room2 ? ST_RD1 : ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_RD1:    state_in = ST_RD2;
         ST_RD2:    state_in = ST_RD3;
         ST_RD3:    state_in = ST_RD4;
         ST_RD4:    state_in = ST_DECODE;
         ST_DECODE: begin
            if (!has_room_need) state_in = ST_EMIT;
            else if (code_ff == CODE_PLAY || code_ff == CODE_BEND) state_in = ST_BTAB;
            else if (is_sound && !def_ff) state_in = ST_DIV;
            else state_in = ST_IDLE;
         end
         ST_BTAB:   state_in = ST_IDLE;
         ST_DIV:    if (div_neg_ff || drsp.done) state_in = ST_MUL;
         ST_MUL:    state_in = ST_EMIT;
         ST_EMIT:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      off_in = off_ff; tempo_in = tempo_ff; res_in = res_ff; vol_in = vol_ff;
      elap_in = elap_ff; sp_in = sp_ff; def_in = def_ff;
      div_neg_in = div_neg_ff; dur_in = dur_ff;
      out_in = out_ff; out_v_in = out_v_ff;
      dreq = '0;
      rep_prod = '0; sum = '0;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      case (state_ff)
         ST_RD0: begin
            if (req_op == OP_RESTART) begin
               off_in = '0; elap_in = '0; tempo_in = 10'sd120; res_in = 8'sd64;
               sp_in = '0; def_in = 1'b0; vol_in = base_vol_ff;
            end else if (req_op == OP_EXEC && !has_room2) begin
               out_in = {elap_ff, 53'd0, KIND_END};
            end
         end
         ST_DECODE: begin
            if (!has_room_need) begin
               out_in = {elap_ff, 53'd0, KIND_END};
            end else begin
               off_in = off_ff + need;
               case (code_ff)
                  CODE_TEMPO: tempo_in = 10'(parm_ff) <<< 2;
                  CODE_RES:   res_in = parm_ff;
                  CODE_BSTART: def_in = 1'b1;
                  CODE_VOL:   vol_in = parm_ff[7] ? 7'd0 : parm_ff[6:0];
                  default: ;
               endcase
               div_neg_in = (tempo_ff <= 0) || (res_ff <= 0);
               dreq.start = is_sound && !def_ff && !((tempo_ff <= 0) || (res_ff <= 0));
               dreq.dividend = numer[31] ? 32'd0 : numer;
               dreq.divisor = divsr;
            end
         end
         ST_BTAB: begin
            if (code_ff == CODE_BEND) begin
               if (sp_ff != '0) begin
                  sp_in = sp_ff - PW'(1);
                  off_in = stack_rd_ff;
               end else def_in = 1'b0;
            end else if (!def_ff && (32'(sp_ff) < STACK_DEPTH) && !parm_ff[7] &&
                         (32'(parm_ff) < BLOCK_COUNT)) begin
               sp_in = sp_ff + PW'(1);
               off_in = btab_rd_ff;
            end
         end
         ST_DIV: if (drsp.done) dur_in = drsp.quotient;
         ST_MUL: begin
            if (code_ff == CODE_REP) rep_prod = 39'(cnt7) * 39'(dur_ff[22:0]);
            else rep_prod = 39'(dur_ff[22:0]);
            if (!div_neg_ff) begin
               sum = {1'b0, elap_ff} + 33'(rep_prod);
               elap_in = (sum[32] || rep_prod[38:33] != '0) ? 32'hFFFF_FFFF : sum[31:0];
            end
         end
         ST_EMIT: out_v_in = 1'b1;
         default: ;
      endcase
      if (state_ff == ST_MUL) begin
         if (div_neg_ff) out_in = {elap_in, 53'd0, KIND_ERR};
         else if (code_ff == CODE_REP)
            out_in = {elap_in, (mute_ff ? 7'd0 : vol_ff), cnt7, dur_ff[22:0],
                      8'd0, (n2_ff[7] ? 8'd0 : n2_ff), KIND_TONE};
         else if (code_ff == CODE_SIL)
            out_in = {elap_in, 7'd0, 7'd1, dur_ff[22:0], 16'd0, KIND_SIL};
         else if (code_ff == CODE_DUAL)
            out_in = {elap_in, (mute_ff ? 7'd0 : vol_ff), 7'd1, dur_ff[22:0],
                      n3_ff, n2_ff, KIND_DUAL};
         else
            out_in = {elap_in, (mute_ff ? 7'd0 : vol_ff), 7'd1, dur_ff[22:0],
                      8'd0, {1'b0, note_clamp}, KIND_TONE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; base_vol_ff <= 7'd80; mute_ff <= 1'b0;
         seq_len_ff <= '0; off_ff <= '0; tempo_ff <= 10'sd120; res_ff <= 8'sd64;
         vol_ff <= 7'd80; elap_ff <= '0; sp_ff <= '0; def_ff <= 1'b0;
         out_v_ff <= 1'b0; bvalid_ff <= '0; wstage_ff <= '0;
      end else begin
         state_ff <= state_in; off_ff <= off_in; tempo_ff <= tempo_in;
         res_ff <= res_in; vol_ff <= vol_in; elap_ff <= elap_in; sp_ff <= sp_in;
         def_ff <= def_in; out_v_ff <= out_v_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_BASE_VOL: base_vol_ff <= csr_wdata[6:0];
               CSR_MUTE:     mute_ff <= csr_wdata[0];
               CSR_SEQ_LEN:  seq_len_ff <= csr_wdata;
               default: ;
            endcase
         end
         // advance the byte read pointer through the event
         if (state_ff == ST_RD0) wstage_ff <= 4'd1;
         else if (state_ff == ST_RD1 || state_ff == ST_RD2 || state_ff == ST_RD3)
            wstage_ff <= wstage_ff + 4'd1;
         else wstage_ff <= '0;
         if (state_ff == ST_DECODE && has_room_need && code_ff == CODE_BSTART &&
             !parm_ff[7] && 32'(parm_ff) < BLOCK_COUNT)
            bvalid_ff[BW'(parm_ff)] <= 1'b1;
      end
      if (req_tvalid && req_tready) item_ff <= req_tdata;
      div_neg_ff <= div_neg_in; dur_ff <= dur_in; out_ff <= out_in;
      // sequence memory: one write, one registered read
      if (state_ff == ST_RD0 && req_op == OP_LOAD && 32'(req_addr) < SEQ_DEPTH)
         seq_mem[AW'(req_addr)] <= req_byte;
      rd_data_ff <= seq_mem[rd_addr[AW-1:0]];
      // the read data arrives in the cycle after its address
      case (state_ff)
         ST_RD1: code_ff <= rd_data_ff;
         ST_RD2: parm_ff <= rd_data_ff;
         ST_RD3: n2_ff <= rd_data_ff;
         ST_RD4: n3_ff <= rd_data_ff;
         default: ;
      endcase
      if (state_ff == ST_DECODE && has_room_need && code_ff == CODE_BSTART &&
          !parm_ff[7] && 32'(parm_ff) < BLOCK_COUNT)
         btab_mem[BW'(parm_ff)] <= off_ff + need;
      btab_rd_ff <= bvalid_ff[BW'(parm_ff)] ? btab_mem[BW'(parm_ff)] : 17'd0;
      if (state_ff == ST_DECODE && has_room_need && code_ff == CODE_PLAY &&
          !def_ff && 32'(sp_ff) < STACK_DEPTH && !parm_ff[7] &&
          32'(parm_ff) < BLOCK_COUNT)
         stack_mem[SW'(sp_ff)] <= off_ff + need;
      stack_rd_ff <= stack_mem[SW'(sp_ff - PW'(1))];
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;
endmodule

### hw/rtl/tsi_checker.sv
// Port-level checker for the tone sequence interpreter, bound to the top.
// Depends on tone_sequence_interpreter_defines.svh.
`include "tone_sequence_interpreter_defines.svh"
module tsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);
   `TSI_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready after beat")
   `TSI_ASSERT_IMPL(a_no_req_while_out, clock, reset, rsp_tvalid, !req_tready, "ready with result pending")
   `TSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
endmodule

bind tone_sequence_interpreter tsi_checker u_tsi_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

### verif/tb.sv
// Self-checking testbench for tone_sequence_interpreter: loads tone sequences,
// executes them and compares each result beat with an in-bench prediction.
// Depends on tsi_pkg and the tone_sequence_interpreter RTL.
`timescale 1ns / 1ps

module tb;
   import tsi_pkg::*;

   typedef struct packed {
      logic [31:0] elapsed;
      logic [6:0]  vol;
      logic [6:0]  rep;
      logic [22:0] dur;
      logic [7:0]  note_b;
      logic [7:0]  note_a;
      logic [2:0]  kind;
   } tone_result_type;

   // Scoreboard: holds predicted tone results and checks returned beats.
   class tone_scoreboard;
      tone_result_type pending[$];
      int errors;

      function void note_input(tone_result_type r);
         pending.push_back(r);
      endfunction

      function void check_result(tone_result_type got);
         tone_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind)
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
         if (got.note_a !== want.note_a)
            $display("%0t: note_a expected %0d actual %0d", $time, want.note_a, got.note_a);
         if (got.note_b !== want.note_b)
            $display("%0t: note_b expected %0d actual %0d", $time, want.note_b, got.note_b);
         if (got.dur !== want.dur)
            $display("%0t: duration expected %0d actual %0d", $time, want.dur, got.dur);
         if (got.rep !== want.rep)
            $display("%0t: repeat expected %0d actual %0d", $time, want.rep, got.rep);
         if (got.vol !== want.vol)
            $display("%0t: volume expected %0d actual %0d", $time, want.vol, got.vol);
         if (got.elapsed !== want.elapsed)
            $display("%0t: elapsed expected %0d actual %0d", $time, want.elapsed,
                     got.elapsed);
         if (got !== want) errors++;
      endfunction
   endclass

   localparam int WATCHDOG     = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   tone_sequence_interpreter u_top (.*);

   always #5 clock = ~clock;

   // Predictor state, a private copy of the sequencer's.
   logic signed [7:0] seq_mem [0:4095];
   bit               seq_written [0:4095];
   int               rd_ofs, tempo, resol, cur_vol, sp;
   logic [31:0]      elapsed;
   int               btab [0:127];
   int               rstack [0:31];
   bit               defining;
   int               base_vol = 80, mute_cfg = 0, seq_len = 0;

   tone_scoreboard sb = new();
   int idle_cycles = 0;
   bit rsp_stall_mode;

   function automatic tone_result_type mk(int k, int a, int b, int d, int r, int v);
      tone_result_type t;
      t.kind = 3'(k); t.note_a = 8'(a); t.note_b = 8'(b); t.dur = 23'(d);
      t.rep = 7'(r); t.vol = 7'(v);
      t.elapsed = elapsed;
      return t;
   endfunction

   function automatic int tone_duration(int parm);
      int d;
      if (tempo <= 0 || resol <= 0) return -1;
      d = (parm * 240000) / (resol * tempo);
      return d < 0 ? 0 : d;
   endfunction

   function automatic void add_elapsed(longint t);
      longint s;
      s = longint'(elapsed) + t;
      elapsed = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic int clamp_note(int n);
      return n < 0 ? 0 : (n > 127 ? 127 : n);
   endfunction

   function automatic void restart_sequence();
      rd_ofs = 0; elapsed = 0; tempo = 120; resol = 64; sp = 0; defining = 0;
      cur_vol = base_vol;
   endfunction

   // True when the next execute beat reads only loaded bytes.
   function automatic bit next_event_safe();
      int len, code;
      len = seq_len < 4096 ? seq_len : 4096;
      if (rd_ofs >= len || len - rd_ofs < 2) return 1;
      if (!seq_written[rd_ofs] || !seq_written[rd_ofs + 1]) return 0;
      code = seq_mem[rd_ofs];
      if ((code == CODE_REP || code == CODE_DUAL) && len - rd_ofs >= 4)
         return seq_written[rd_ofs + 2] && seq_written[rd_ofs + 3];
      return 1;
   endfunction

   // Predict one accepted request; push a result when one is due.
   function automatic void predict_request(logic [1:0] op, int addr, logic [7:0] b);
      int len, code, parm, n2, n3, need, d, vol, cnt;
      vol = mute_cfg ? 0 : cur_vol;
      if (op == OP_LOAD) begin
         seq_mem[addr] = b; seq_written[addr] = 1;
         return;
      end
      if (op == OP_RESTART) begin
         restart_sequence();
         return;
      end
      if (op != OP_EXEC) return;
      len = seq_len < 4096 ? seq_len : 4096;
      if (rd_ofs >= len || len - rd_ofs < 2) begin
         sb.note_input(mk(KIND_END, 0, 0, 0, 0, 0));
         return;
      end
      code = seq_mem[rd_ofs];
      parm = seq_mem[rd_ofs + 1];
      need = (code == CODE_REP || code == CODE_DUAL) ? 4 : 2;
      if (len - rd_ofs < need) begin
         sb.note_input(mk(KIND_END, 0, 0, 0, 0, 0));
         return;
      end
      n2 = need == 4 ? int'(seq_mem[rd_ofs + 2]) : 0;
      n3 = need == 4 ? int'(seq_mem[rd_ofs + 3]) : 0;
      rd_ofs += need;
      case (code)
         CODE_VER: return;
         CODE_TEMPO: begin tempo = parm * 4; return; end
         CODE_RES: begin resol = parm; return; end
         CODE_BSTART: begin
            defining = 1;
            if (parm >= 0) btab[parm] = rd_ofs;
            return;
         end
         CODE_BEND: begin
            if (sp > 0) begin sp--; rd_ofs = rstack[sp]; end
            else defining = 0;
            return;
         end
         CODE_PLAY: begin
            if (!defining && sp < 32 && parm >= 0) begin
               rstack[sp] = rd_ofs; sp++; rd_ofs = btab[parm];
            end
            return;
         end
         CODE_VOL: begin cur_vol = parm < 0 ? 0 : parm; return; end
         default: ;
      endcase
      if (defining) return;
      if (code == CODE_REP) begin
         cnt = parm < 0 ? 0 : parm;
         d = tone_duration(n3);
         if (d < 0) begin sb.note_input(mk(KIND_ERR, 0, 0, 0, 0, 0)); return; end
         add_elapsed(longint'(cnt) * d);
         sb.note_input(mk(KIND_TONE, clamp_note(n2), 0, d, cnt, vol));
         return;
      end
      d = tone_duration(parm);
      if (d < 0) begin sb.note_input(mk(KIND_ERR, 0, 0, 0, 0, 0)); return; end
      add_elapsed(d);
      if (code == CODE_SIL) sb.note_input(mk(KIND_SIL, 0, 0, d, 1, 0));
      else if (code == CODE_DUAL) sb.note_input(mk(KIND_DUAL, n2, n3, d, 1, vol));
      else sb.note_input(mk(KIND_TONE, clamp_note(code), 0, d, 1, vol));
   endfunction

   // Count a cycle with no accepted beat on either side; give up at the limit.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tone_sequence_interpreter test failed");
         $finish;
      end
   end

   // Receiver: check each accepted result, stall on a pattern of its own.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ($urandom_range(0, 199) == 0) rsp_stall_mode <= ~rsp_stall_mode;
         rsp_tready <= rsp_stall_mode ? ($urandom_range(0, 7) == 0)
                                      : ($urandom_range(0, 3) != 0);
      end
   end

   // Send one request beat in burst style; predict at acceptance.
   task automatic send_req(logic [1:0] op, int addr, int b);
      req_tvalid <= 1;
      req_tdata  <= {2'b00, 8'(b), addr[11:0], op};
      do @(posedge clock); while (!req_tready);
      predict_request(op, addr, 8'(b));
      if ($urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Hold the sender, wait for the block to go idle, then write one register.
   task automatic write_csr(logic [1:0] idx, int val);
      req_tvalid <= 0;
      do @(posedge clock); while (!req_tready);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= 13'(val);
      @(posedge clock);
      csr_wen <= 0;
      case (idx)
         CSR_BASE_VOL: base_vol = val & 8'h7F;
         CSR_MUTE:     mute_cfg = val & 1;
         default:      seq_len  = val & 13'h1FFF;
      endcase
   endtask

   // Load a byte pair at a running address.
   task automatic put_event(inout int a, input int c, input int p);
      send_req(OP_LOAD, a, c); send_req(OP_LOAD, a + 1, p); a += 2;
   endtask

   // Build a random but well-formed program of length n from address 0.
   task automatic load_program(int n);
      int a, c, k;
      a = 0;
      while (a < n - 4) begin
         k = $urandom_range(0, 19);
         case (k)
            0: put_event(a, CODE_TEMPO, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 255) : $urandom_range(10, 60));
            1: put_event(a, CODE_RES, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 255) : $urandom_range(8, 127));
            2: put_event(a, CODE_VOL, $urandom_range(0, 255));
            3: put_event(a, CODE_BSTART, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 255) : $urandom_range(0, 3));
            4: put_event(a, CODE_BEND, $urandom_range(0, 255));
            5: put_event(a, CODE_PLAY, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 255) : $urandom_range(0, 3));
            6: put_event(a, CODE_SIL, $urandom_range(0, 255));
            7: put_event(a, CODE_VER, $urandom_range(0, 255));
            8: begin put_event(a, CODE_REP, $urandom_range(0, 255));
               put_event(a, $urandom_range(0, 255), $urandom_range(0, 255)); end
            9: begin put_event(a, CODE_DUAL, $urandom_range(0, 255));
               put_event(a, $urandom_range(0, 255), $urandom_range(0, 255)); end
            10: put_event(a, $urandom_range(128, 255), $urandom_range(0, 255));
            default: put_event(a, $urandom_range(0, 127), $urandom_range(0, 255));
         endcase
      end
      // Fill the tail so every byte below the length is loaded.
      while (a < n + 4) begin
         c = $urandom_range(0, 127);
         send_req(OP_LOAD, a, c); a++;
      end
   endtask

   // Stop early where the next event would reach bytes never loaded.
   task automatic run_program(int n, int execs);
      write_csr(CSR_SEQ_LEN, n);
      send_req(OP_RESTART, $urandom_range(0, 4095), $urandom_range(0, 255));
      for (int i = 0; i < execs; i++) begin
         if (!next_event_safe()) break;
         send_req(OP_EXEC, $urandom_range(0, 4095), $urandom_range(0, 255));
      end
   endtask

   int sent, a, n;

   initial begin
      for (int i = 0; i < 128; i++) btab[i] = 0;
      for (int i = 0; i < 4096; i++) seq_written[i] = 0;
      restart_sequence();
      cur_vol = 80;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, tone, dual, repeat, volume, tempo and resolution codes, end of data and bad divisors.
      a = 0;
      put_event(a, 127, 127);
      put_event(a, CODE_VOL, 127);
      put_event(a, -128, 1);
      put_event(a, CODE_DUAL, -128);
      put_event(a, -128, 127);
      put_event(a, CODE_REP, 127);
      put_event(a, 60, 127);
      put_event(a, CODE_RES, 0);
      put_event(a, 10, 10);
      put_event(a, CODE_TEMPO, -1);
      send_req(OP_LOAD, 4095, 8'hFF);
      write_csr(CSR_BASE_VOL, 127);
      write_csr(CSR_MUTE, 1);
      run_program(a, 8);
      drain();
      write_csr(CSR_MUTE, 0);
      write_csr(CSR_BASE_VOL, 0);
      run_program(a - 1, 3);
      write_csr(CSR_SEQ_LEN, 0);
      drain();
      run_program(0, 1);
      send_req(OP_UNUSED, 4095, 8'hFF);
      drain();

      // Random programs with random content, then pauses to reconfigure.
      sent = 0;
      while (sent < 800) begin
         n = $urandom_range(0, 7) == 0 ? $urandom_range(40, 200) : $urandom_range(8, 40);
         load_program(n);
         write_csr(CSR_BASE_VOL, $urandom_range(0, 127));
         write_csr(CSR_MUTE, $urandom_range(0, 1));
         run_program($urandom_range(0, 15) == 0 ? 4096 + $urandom_range(0, 1) : n,
                     $urandom_range(n / 2, n));
         sent += n + n + 4;
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tone_sequence_interpreter test passed");
      else
         $display("tone_sequence_interpreter test failed");
      $finish;
   end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tsi_pkg.sv
hw/rtl/tsi_divider.sv
hw/rtl/tone_sequence_interpreter.sv
hw/rtl/tsi_checker.sv
verif/tb.sv
